// File: rtl/slco_pkg.sv
// Shared types and constants for the segment label color overlay.
// Holds the palette write bundle, the RGB triple and the sector color map.
// No dependencies.
package slco_pkg;

	localparam int unsigned LABEL_W = 8;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned HUE_W   = 9;

	localparam logic [CHAN_W-1:0] COLOR_HIGH = 8'd204;
	localparam logic [CHAN_W-1:0] COLOR_LOW  = 8'd20;

	// 360 degrees, dividend of the hue step.
	localparam logic [HUE_W-1:0] FULL_TURN = 9'd360;
	localparam logic [5:0]       SECTOR_DEG = 6'd60;
	// ceil(2^16 / 60): exact sector for every hue below 360.
	localparam logic [10:0]      SECTOR_RECIP = 11'd1093;
	// ceil(2^19 / 100): exact quotient for every mid numerator up to 20400.
	localparam logic [12:0]      MID_RECIP = 13'd5243;
	localparam logic [10:0]      MID_BASE = 11'd2040;
	localparam logic [8:0]       MID_SLOPE = 9'd306;

	localparam logic [2:0] SECTOR_RG = 3'd0;
	localparam logic [2:0] SECTOR_GR = 3'd1;
	localparam logic [2:0] SECTOR_GB = 3'd2;
	localparam logic [2:0] SECTOR_BG = 3'd3;
	localparam logic [2:0] SECTOR_BR = 3'd4;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		logic               en;
		logic [LABEL_W-1:0] addr;
		rgb_t               data;
	} pal_wr_t;

	function automatic rgb_t sector_color(input logic [2:0] sector, input logic [CHAN_W-1:0] mid);
		rgb_t c;
		case (sector)
			SECTOR_RG: begin c.red = COLOR_HIGH; c.green = mid;        c.blue = COLOR_LOW;  end
			SECTOR_GR: begin c.red = mid;        c.green = COLOR_HIGH; c.blue = COLOR_LOW;  end
			SECTOR_GB: begin c.red = COLOR_LOW;  c.green = COLOR_HIGH; c.blue = mid;        end
			SECTOR_BG: begin c.red = COLOR_LOW;  c.green = mid;        c.blue = COLOR_HIGH; end
			SECTOR_BR: begin c.red = mid;        c.green = COLOR_LOW;  c.blue = COLOR_HIGH; end
			default:   begin c.red = COLOR_HIGH; c.green = COLOR_LOW;  c.blue = mid;        end
		endcase
		return c;
	endfunction

endpackage

// File: rtl/slco_div.sv
// Bit-serial restoring divider that forms the hue step 360 / plane_count.
// One quotient bit per cycle, most significant bit first. Uses slco_pkg.
module slco_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [slco_pkg::LABEL_W-1:0] divisor,
	output logic                         done,
	output logic [slco_pkg::HUE_W-1:0]   quotient
);
	import slco_pkg::*;

	logic                busy_q;
	logic [3:0]          cnt_q;
	logic [HUE_W-1:0]    num_q;
	logic [HUE_W-1:0]    quo_q;
	logic [LABEL_W-1:0]  rem_q;
	logic                done_q;
	logic [HUE_W-1:0]    trial;
	logic                fits;

	// The remainder always stays below the divisor, so eight bits hold it.
	assign trial = {rem_q, num_q[HUE_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(HUE_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= FULL_TURN;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[HUE_W-2:0], 1'b0};
			quo_q <= {quo_q[HUE_W-2:0], fits};
			rem_q <= fits ? LABEL_W'(trial - {1'b0, divisor}) : trial[LABEL_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/slco_palette_gen.sv
// Palette builder: after a nonzero plane count write it sweeps labels 1..255, forms
// each label's hue and HSV color, and writes it to the palette memory. Uses slco_div, slco_pkg.
module slco_palette_gen (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [slco_pkg::LABEL_W-1:0] cfg_data,
	input  logic [slco_pkg::LABEL_W-1:0] plane_count,
	output slco_pkg::pal_wr_t            pal_wr,
	output logic                         busy
);
	import slco_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DIV   = 3'b010,
		ST_SWEEP = 3'b100
	} gen_state_t;

	gen_state_t          state_q;
	logic                div_done;
	logic [HUE_W-1:0]    div_quo;
	logic [HUE_W-1:0]    step_q;
	logic [LABEL_W-1:0]  lbl_q;
	logic [LABEL_W-1:0]  idx_q;
	logic [HUE_W-1:0]    hue_q;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [LABEL_W-1:0]  lbl_s1, lbl_s2, lbl_s3, lbl_s4;
	logic [2:0]          sector_s1, sector_s2, sector_s3, sector_s4;
	logic [HUE_W-1:0]    hue_s1;
	logic [5:0]          t_s2;
	logic [14:0]         x_s3;
	logic [CHAN_W-1:0]   mid_s4;

	logic [19:0]         sector_prod;
	logic [HUE_W-1:0]    sector_base;
	logic [5:0]          d;
	logic [27:0]         mid_prod;

	slco_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_we && (cfg_data != '0)),
		.divisor  (plane_count),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_we && (cfg_data != '0)) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (lbl_q == '1) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Label and color index advance together; the hue restarts whenever the
	// index wraps at the plane count.
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			step_q <= div_quo;
			lbl_q  <= LABEL_W'(1);
			idx_q  <= '0;
			hue_q  <= '0;
		end else if (state_q == ST_SWEEP) begin
			lbl_q <= lbl_q + LABEL_W'(1);
			if (idx_q == plane_count - LABEL_W'(1)) begin
				idx_q <= '0;
				hue_q <= '0;
			end else begin
				idx_q <= idx_q + LABEL_W'(1);
				hue_q <= hue_q + step_q;
			end
		end
	end

	assign sector_prod = 20'(hue_q) * 20'(SECTOR_RECIP);
	assign sector_base = 9'(sector_s1) * 9'(SECTOR_DEG);
	assign d           = 6'(hue_s1 - sector_base);
	assign mid_prod    = 28'(x_s3) * 28'(MID_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SWEEP);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		lbl_s1    <= lbl_q;
		hue_s1    <= hue_q;
		sector_s1 <= sector_prod[18:16];

		lbl_s2    <= lbl_s1;
		sector_s2 <= sector_s1;
		// Odd sectors run the mid channel backward.
		t_s2      <= sector_s1[0] ? (SECTOR_DEG - d) : d;

		lbl_s3    <= lbl_s2;
		sector_s3 <= sector_s2;
		x_s3      <= 15'(MID_BASE) + 15'(MID_SLOPE) * 15'(t_s2);

		lbl_s4    <= lbl_s3;
		sector_s4 <= sector_s3;
		mid_s4    <= mid_prod[26:19];
	end

	assign pal_wr.en   = v_s4;
	assign pal_wr.addr = lbl_s4;
	assign pal_wr.data = sector_color(sector_s4, mid_s4);

	assign busy = (state_q != ST_IDLE) || v_s1 || v_s2 || v_s3 || v_s4;

endmodule

// File: rtl/slco_blend.sv
// Pixel path: palette memory lookup by segment label and blend with the
// gray intensity, with an input skid word and an output register. Uses slco_pkg.
module slco_blend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [slco_pkg::LABEL_W-1:0] plane_count,
	input  slco_pkg::pal_wr_t            pal_wr,
	input  logic                         busy,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [15:0]                  s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [23:0]                  m_axis_tdata
);
	import slco_pkg::*;

	rgb_t                pal_mem [2**LABEL_W];
	rgb_t                rd_s1;

	logic                skid_full_q;
	logic [15:0]         skid_q;
	logic                v_s1;
	logic                pass_s1;
	logic [CHAN_W-1:0]   gray_s1;
	logic                out_valid_q;
	rgb_t                out_q;

	logic                advance;
	logic                in_acc;
	logic                src_valid;
	logic [15:0]         src;
	logic [CHAN_W-1:0]   src_gray;
	logic [LABEL_W-1:0]  src_label;
	logic [CHAN_W:0]     sum_r, sum_g, sum_b;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !skid_full_q && !busy;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign src_valid     = skid_full_q || in_acc;
	assign src           = skid_full_q ? skid_q : s_axis_tdata;
	assign src_gray      = src[7:0];
	assign src_label     = src[15:8];

	always_ff @(posedge clk) begin
		if (pal_wr.en) pal_mem[pal_wr.addr] <= pal_wr.data;
	end

	always_ff @(posedge clk) begin
		if (advance) rd_s1 <= pal_mem[src_label];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				skid_full_q <= 1'b0;
				v_s1        <= src_valid;
				out_valid_q <= v_s1;
			end else if (in_acc) begin
				skid_full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!advance && in_acc) skid_q <= s_axis_tdata;
		if (advance) begin
			gray_s1 <= src_gray;
			pass_s1 <= (src_label == '0) || (plane_count == '0);
		end
	end

	assign sum_r = {1'b0, gray_s1} + {1'b0, rd_s1.red};
	assign sum_g = {1'b0, gray_s1} + {1'b0, rd_s1.green};
	assign sum_b = {1'b0, gray_s1} + {1'b0, rd_s1.blue};

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pass_s1) begin
				out_q.red   <= gray_s1;
				out_q.green <= gray_s1;
				out_q.blue  <= gray_s1;
			end else begin
				out_q.red   <= sum_r[CHAN_W:1];
				out_q.green <= sum_g[CHAN_W:1];
				out_q.blue  <= sum_b[CHAN_W:1];
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

// File: rtl/segment_label_color_overlay_top.sv
// Top level of the segment label color overlay.
// Holds the plane count register and joins the palette builder and the pixel path.
// Uses slco_pkg, slco_palette_gen, slco_blend.

// A new pixel word can be accepted every cycle unless the palette rebuild or
// output back-pressure holds s_axis_tready low; its blended color passes the
// synchronous palette memory read and then the output register. Labels are
// colored from a 256-entry palette memory; writing a nonzero plane_count
// rebuilds it: the serial hue-step divider runs, one palette write follows for
// each of the 255 labels, the color pipeline drains, and s_axis_tready stays
// low throughout. Writing zero selects gray passthrough and needs no rebuild.
// Write plane_count only while no pixel is in flight.
module segment_label_color_overlay_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,        // plane_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // [7:0] intensity, [15:8] seg_label
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata     // [7:0] red, [15:8] green, [23:16] blue
);
	import slco_pkg::*;

	logic [LABEL_W-1:0] plane_count_q;
	pal_wr_t            pal_wr;
	logic               gen_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= '0;
		end else if (cfg_we) begin
			plane_count_q <= cfg_data;
		end
	end

	slco_palette_gen u_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.plane_count (plane_count_q),
		.pal_wr      (pal_wr),
		.busy        (gen_busy)
	);

	slco_blend u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.plane_count   (plane_count_q),
		.pal_wr        (pal_wr),
		.busy          (gen_busy),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// File: bench/tb.sv
// Self-checking bench for segment_label_color_overlay_top: drives pixel words and
// plane count writes, predicts each blended RGB word and compares it on the output.
// Depends on slco_pkg and the RTL top only.
`timescale 1ns / 100ps

module tb;
	import slco_pkg::*;

	localparam int unsigned CLK_HALF       = 4;
	localparam int unsigned RESET_CYCLES   = 6;
	// Ten palette rebuilds plus 420 words under heavy stalls stay far below this.
	localparam int unsigned LIMIT_CYCLES   = 200000;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned RX_HOLD_CYCLES = 80;
	localparam int unsigned MAX_REPORTS    = 100;

	typedef enum logic [1:0] {GAPS_NONE, GAPS_SEND, GAPS_RECV, GAPS_BOTH} gap_mode_t;

	typedef struct packed {
		logic [7:0] seg_label;
		logic [7:0] intensity;
	} pixel_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [7:0]  cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	segment_label_color_overlay_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	pixel_t      pixel_backlog[$];
	rgb_t        overlay_due[$];
	logic [7:0]  planes_now = '0;
	gap_mode_t   gap_mode   = GAPS_NONE;
	logic        in_fire    = 1'b0;
	logic        rx_hold    = 1'b0;
	logic        rx_hold_go = 1'b0;
	int unsigned cycles         = 0;
	int unsigned error_count    = 0;
	int unsigned pixels_sent    = 0;
	int unsigned pixels_checked = 0;
	int unsigned plane_writes   = 0;
	int unsigned input_stalls   = 0;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Colorize one pixel for a given plane count and blend it with its gray value.
	function automatic rgb_t blend_overlay(input pixel_t px, input logic [7:0] planes);
		int unsigned deg_step, color_idx, hue, d, t, mid;
		logic [2:0]  sector;
		int unsigned chan [3];
		rgb_t        res;
		if (px.seg_label == 0 || planes == 0) begin
			res.red   = px.intensity;
			res.green = px.intensity;
			res.blue  = px.intensity;
			return res;
		end
		deg_step  = 360 / planes;
		color_idx = (px.seg_label - 1) % planes;
		hue       = (color_idx * deg_step) % 360;
		sector    = 3'(hue / 60);
		d         = hue % 60;
		// The mid channel falls in odd sectors, so the offset is mirrored there.
		t         = sector[0] ? 60 - d : d;
		mid       = (2040 + 306 * t) / 100;
		case (sector)
			SECTOR_RG: chan = '{COLOR_HIGH, mid, COLOR_LOW};
			SECTOR_GR: chan = '{mid, COLOR_HIGH, COLOR_LOW};
			SECTOR_GB: chan = '{COLOR_LOW, COLOR_HIGH, mid};
			SECTOR_BG: chan = '{COLOR_LOW, mid, COLOR_HIGH};
			SECTOR_BR: chan = '{mid, COLOR_LOW, COLOR_HIGH};
			default:   chan = '{COLOR_HIGH, COLOR_LOW, mid};
		endcase
		res.red   = 8'((px.intensity + chan[0]) >> 1);
		res.green = 8'((px.intensity + chan[1]) >> 1);
		res.blue  = 8'((px.intensity + chan[2]) >> 1);
		return res;
	endfunction

	function automatic bit send_gap();
		return (gap_mode == GAPS_SEND && $urandom_range(99) < 54) ||
			(gap_mode == GAPS_BOTH && $urandom_range(99) < 8);
	endfunction

	function automatic bit recv_stall();
		return (gap_mode == GAPS_RECV && $urandom_range(99) < 54) ||
			(gap_mode == GAPS_BOTH && $urandom_range(99) < 8);
	endfunction

	// Only the first lines are printed to keep the log short; every mismatch counts.
	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (error_count < MAX_REPORTS) begin
			$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		end
		error_count++;
	endtask

	// Input words are offered at the falling edge; a new one goes out once the
	// current word was taken at the last rising edge.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (pixel_backlog.size() != 0 && !send_gap()) begin
				s_axis_tdata  <= pixel_backlog.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || rx_hold) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !recv_stall();
		end
	end

	// Long receiver hold-off, so the pipeline fills and pushes back on the input.
	// It starts once words are flowing, after the palette rebuild has finished.
	initial begin
		wait (rx_hold_go);
		wait (s_axis_tvalid && s_axis_tready);
		rx_hold = 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	always @(posedge clk) begin : monitor
		rgb_t got, want;
		in_fire = s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (overlay_due.size() == 0) begin
				report_mismatch("output word with nothing expected", 32'(got), 0);
			end else begin
				want = overlay_due.pop_front();
				pixels_checked++;
				if (got.red !== want.red)
					report_mismatch("red", 32'(got.red), 32'(want.red));
				if (got.green !== want.green)
					report_mismatch("green", 32'(got.green), 32'(want.green));
				if (got.blue !== want.blue)
					report_mismatch("blue", 32'(got.blue), 32'(want.blue));
			end
		end
		if (in_fire) begin
			overlay_due.insert(overlay_due.size(),
				blend_overlay(pixel_t'(s_axis_tdata), planes_now));
			pixels_sent++;
		end
		if (s_axis_tvalid && !s_axis_tready) input_stalls++;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				overlay_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic drain();
		while (pixel_backlog.size() != 0 || s_axis_tvalid || overlay_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A nonzero plane count starts a palette rebuild; the block holds tready low
	// meanwhile, so words queued afterward simply wait for it.
	task automatic write_planes(input logic [7:0] value);
		drain();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we     <= 1'b0;
		planes_now = value;
		plane_writes++;
		repeat (2) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic queue_pixel(input logic [7:0] gray, input logic [7:0] label);
		pixel_backlog.insert(pixel_backlog.size(), pixel_t'({label, gray}));
	endtask

	// Mostly labels inside the plane range, some label zero, the rest anywhere.
	task automatic queue_random(input int unsigned count);
		int unsigned pick;
		logic [7:0]  label;
		repeat (count) begin
			pick = $urandom_range(9);
			if (pick == 0) begin
				label = '0;
			end else if (pick <= 5 && planes_now != 0) begin
				label = 8'($urandom_range(32'(planes_now), 1));
			end else begin
				label = 8'($urandom);
			end
			queue_pixel(8'($urandom), label);
		end
	endtask

	initial begin : stimulus
		int k;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Plane count still at its reset value: gray passthrough for any label.
		queue_pixel(8'd0, 8'd0);
		queue_pixel(8'd255, 8'd255);
		queue_pixel(8'hA5, 8'h5A);

		// One plane: every label maps to hue zero.
		write_planes(8'd1);
		queue_pixel(8'd255, 8'd1);
		queue_pixel(8'd0, 8'd255);
		queue_pixel(8'd128, 8'd0);

		// Six planes hit each sector start; label seven wraps back to red.
		write_planes(8'd6);
		for (k = 1; k <= 7; k++) queue_pixel(8'(k * 37), 8'(k));

		// Step of 51 degrees puts hues inside sectors, odd ones included.
		write_planes(8'd7);
		queue_pixel(8'd200, 8'd2);
		queue_pixel(8'd17, 8'd4);
		queue_pixel(8'd99, 8'd7);

		// Largest count: one degree per label, across a sector boundary.
		write_planes(8'd255);
		queue_pixel(8'd255, 8'd1);
		queue_pixel(8'd0, 8'd60);
		queue_pixel(8'd77, 8'd61);
		queue_pixel(8'd255, 8'd255);

		write_planes(8'($urandom_range(255, 1)));
		gap_mode = GAPS_NONE;
		queue_random(60);

		write_planes(8'd0);
		gap_mode = GAPS_SEND;
		queue_random(40);

		write_planes(8'($urandom_range(255, 1)));
		gap_mode = GAPS_RECV;
		queue_random(70);

		write_planes(8'd255);
		gap_mode = GAPS_BOTH;
		queue_random(60);

		write_planes(8'($urandom_range(12, 2)));
		gap_mode = GAPS_NONE;
		queue_random(60);
		rx_hold_go = 1'b1;

		// The sender stops halfway until every result is back.
		write_planes(8'($urandom_range(255, 1)));
		gap_mode = GAPS_BOTH;
		queue_random(30);
		drain();
		queue_random(30);

		write_planes(8'd13);
		gap_mode = GAPS_SEND;
		queue_random(50);

		drain();
		$display("Overlay run: %0d pixels sent, %0d results compared, %0d plane count writes",
			pixels_sent, pixels_checked, plane_writes);
		$display("Input stalled %0d cycles; gray passthrough, label wrap and all hue sectors hit",
			input_stalls);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
